@@ rtl/kmeans_clustering_2d_macros.svh @@
// kmeans_clustering_2d_macros.svh: assertion macros for the k-means block
// depends on nothing; included by the top level only
`ifndef KMEANS_CLUSTERING_2D_MACROS_SVH
`define KMEANS_CLUSTERING_2D_MACROS_SVH

// same-cycle implication check, clocked on rising clk, off during reset
`define KMC_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication check
`define KMC_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/kmc_pkg.sv @@
// kmc_pkg: shared constants and request codes for the k-means block
// depends on nothing
`default_nettype none

package kmc_pkg;

    localparam int MAX_POINTS_DEF   = 1024;
    localparam int MAX_CLUSTERS_DEF = 20;
    localparam int COORD_BITS_DEF   = 32;

    localparam int REQ_W      = 3;
    localparam int INDEX_W    = 10;
    localparam int LABEL_W    = 5;
    localparam int ITER_W     = 16;
    localparam int PCOUNT_W   = 11;
    localparam int KCOUNT_W   = 5;
    localparam int CFG_DATA_W = 11;
    localparam int CFG_IDX_W  = 1;

    localparam logic [ITER_W-1:0] ROUND_CAP = 16'hFFFF;

    localparam logic [CFG_IDX_W-1:0] CFG_POINT_COUNT   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLUSTER_COUNT = 1'b1;

    typedef enum logic [REQ_W-1:0] {
        REQ_LOAD_POINT  = 3'd0,
        REQ_LOAD_CENTER = 3'd1,
        REQ_RUN         = 3'd2,
        REQ_READ_LABEL  = 3'd3,
        REQ_READ_CENTER = 3'd4
    } req_t;

endpackage

`default_nettype wire

@@ rtl/kmeans_clustering_2d.sv @@
// kmeans_clustering_2d: lloyd k-means over 2-d q16.16 points, memory based
// depends on kmc_pkg and kmeans_clustering_2d_macros.svh
//
// channel  | signals                                    | role
// ---------+--------------------------------------------+------------------------
// in       | in_valid in_ready req_type item_index      | load / run / read request
//          | coord_x coord_y                            |
// out      | out_valid out_ready label center_x         | one result per request
//          | center_y iterations status                 |
// cfg      | cfg_write cfg_index cfg_data               | point_count, cluster_count
//
// loads, unknown requests and out-of-range indexes answer at once, in-range reads
// after the registered memory read; a run repeats rounds of an assign step that
// compares each point with every center in the single distance unit and an update
// step that divides each nonempty center's sums in the bit-serial divider and skips each empty one
// after reset a clearing pass zeroes the label memory
// in_ready is low during clearing, during a run, while a read is answered,
// and while a waiting result is not taken
`default_nettype none
`include "kmeans_clustering_2d_macros.svh"

module kmeans_clustering_2d #(
    parameter int MAX_POINTS   = kmc_pkg::MAX_POINTS_DEF,
    parameter int MAX_CLUSTERS = kmc_pkg::MAX_CLUSTERS_DEF,
    parameter int COORD_BITS   = kmc_pkg::COORD_BITS_DEF
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 cfg_write,
    input  wire  [kmc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire  [kmc_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  wire                                 in_valid,
    output logic                                in_ready,
    input  wire  [kmc_pkg::REQ_W-1:0]           req_type,
    input  wire  [kmc_pkg::INDEX_W-1:0]         item_index,
    input  wire  signed [COORD_BITS-1:0]        coord_x,
    input  wire  signed [COORD_BITS-1:0]        coord_y,
    output logic                                out_valid,
    input  wire                                 out_ready,
    output logic [kmc_pkg::LABEL_W-1:0]         label,
    output logic signed [COORD_BITS-1:0]        center_x,
    output logic signed [COORD_BITS-1:0]        center_y,
    output logic [kmc_pkg::ITER_W-1:0]          iterations,
    output logic                                status
);
    import kmc_pkg::*;

    // widths derived from the store sizes
    localparam int PT_AW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CL_AW  = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int CK_W   = $clog2(MAX_CLUSTERS + 1);
    localparam int SUM_W  = COORD_BITS + PT_AW;
    localparam int DIF_W  = COORD_BITS + 1;
    localparam int SQ_W   = 2 * DIF_W;
    localparam int DST_W  = SQ_W + 1;
    localparam int DS_W   = $clog2(SUM_W + 1);
    localparam logic [DS_W-1:0]  DIV_LAST = DS_W'(SUM_W - 1);
    localparam logic [CNT_W-1:0] PT_LAST  = CNT_W'(MAX_POINTS - 1);

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_RESP, S_PT, S_CRD, S_DIFF, S_SQ, S_CMP,
        S_ACC, S_UPD, S_DIVX, S_DIVY, S_WR, S_ROUND, S_DONE
    } state_t;

    state_t state_reg;

    // configuration registers
    logic [PCOUNT_W-1:0] point_count_reg;
    logic [KCOUNT_W-1:0] cluster_count_reg;

    // memories
    logic [COORD_BITS-1:0] pt_x_mem [MAX_POINTS];
    logic [COORD_BITS-1:0] pt_y_mem [MAX_POINTS];
    logic [CL_AW-1:0]      lbl_mem  [MAX_POINTS];
    logic [COORD_BITS-1:0] ct_x_mem [MAX_CLUSTERS];
    logic [COORD_BITS-1:0] ct_y_mem [MAX_CLUSTERS];

    logic [COORD_BITS-1:0] px_rd_reg, py_rd_reg, cx_rd_reg, cy_rd_reg;
    logic [CL_AW-1:0]      lbl_rd_reg;

    // per-cluster accumulators, one shared read address
    logic [SUM_W-1:0] sum_x_reg [MAX_CLUSTERS];
    logic [SUM_W-1:0] sum_y_reg [MAX_CLUSTERS];
    logic [CNT_W-1:0] cnt_reg   [MAX_CLUSTERS];

    // sequencer registers
    logic [CNT_W-1:0]          pi_reg;
    logic [CK_W-1:0]           ci_reg;
    logic [CK_W-1:0]           bidx_reg;
    logic [DST_W-1:0]          best_reg;
    logic signed [DIF_W-1:0]   dx_reg, dy_reg;
    logic [SQ_W-1:0]           sqx_reg, sqy_reg;
    logic                      changed_reg;
    logic [ITER_W-1:0]         rounds_reg;
    logic [REQ_W-1:0]          rq_reg;

    // divider
    logic [SUM_W-1:0]      dq_reg;
    logic [CNT_W:0]        dr_reg;
    logic [CNT_W-1:0]      dcnt_reg;
    logic                  dneg_reg;
    logic [DS_W-1:0]       dstep_reg;
    logic [COORD_BITS-1:0] newx_reg, newy_reg;

    // output register
    logic                  out_valid_reg;
    logic [LABEL_W-1:0]    label_reg;
    logic [COORD_BITS-1:0] cx_out_reg, cy_out_reg;
    logic [ITER_W-1:0]     iter_reg;
    logic                  status_reg;

    // combinational
    logic                  slot_free, accept, pt_oor, ct_oor, out_load;
    logic [CNT_W-1:0]      n_eff;
    logic [CK_W-1:0]       k_eff;
    logic [PT_AW-1:0]      req_pt_addr, pt_addr;
    logic [CL_AW-1:0]      req_ct_addr, ct_addr, acc_addr;
    logic                  pt_we, pt_re, lbl_we, ct_we, ct_re;
    logic [CL_AW-1:0]      lbl_wdata;
    logic [COORD_BITS-1:0] ct_wx, ct_wy;
    logic [DST_W-1:0]      dist_sum;
    logic [CNT_W:0]        rem_sh, dr_next;
    logic                  rem_ge;
    logic [SUM_W-1:0]      dq_next;
    logic [SUM_W-1:0]      acc_x, acc_y;
    logic [CNT_W-1:0]      acc_cnt;
    logic [ITER_W-1:0]     rounds_next;
    logic                  lbl_diff;

    function automatic logic [SUM_W-1:0] mag_of(input logic [SUM_W-1:0] v);
        mag_of = v[SUM_W-1] ? (~v + SUM_W'(1)) : v;
    endfunction

    function automatic logic [COORD_BITS-1:0] signed_q(input logic [SUM_W-1:0] q,
                                                       input logic neg);
        logic [COORD_BITS-1:0] t;
        t = q[COORD_BITS-1:0];
        signed_q = neg ? (~t + COORD_BITS'(1)) : t;
    endfunction

    function automatic logic [SUM_W-1:0] sext(input logic [COORD_BITS-1:0] v);
        sext = {{(SUM_W-COORD_BITS){v[COORD_BITS-1]}}, v};
    endfunction

    always_comb
    begin
        slot_free = !out_valid_reg || out_ready;
        in_ready  = (state_reg == S_IDLE) && slot_free;
        accept    = in_valid && in_ready;

        pt_oor = (32'(item_index) >= MAX_POINTS);
        ct_oor = (32'(item_index) >= MAX_CLUSTERS);
        req_pt_addr = PT_AW'(item_index);
        req_ct_addr = CL_AW'(item_index);

        // a result is placed: at once for loads, unknown codes and bad indexes,
        // after the memory read for reads, and at the end of a run
        out_load = (accept && (req_type != REQ_RUN) &&
                    !(((req_type == REQ_READ_LABEL) && !pt_oor) ||
                      ((req_type == REQ_READ_CENTER) && !ct_oor)))
                   || (((state_reg == S_RESP) || (state_reg == S_DONE)) && slot_free);

        // clamp the configuration to the store sizes; a cluster count of zero counts as one
        n_eff = (32'(point_count_reg) > MAX_POINTS) ? CNT_W'(MAX_POINTS)
                                                    : CNT_W'(point_count_reg);
        if (cluster_count_reg == '0)
            k_eff = CK_W'(1);
        else if (32'(cluster_count_reg) > MAX_CLUSTERS)
            k_eff = CK_W'(MAX_CLUSTERS);
        else
            k_eff = CK_W'(cluster_count_reg);

        // point and label memory port
        pt_addr = (state_reg == S_IDLE) ? req_pt_addr : pi_reg[PT_AW-1:0];
        pt_we   = accept && (req_type == REQ_LOAD_POINT) && !pt_oor;
        pt_re   = (accept && (req_type == REQ_READ_LABEL) && !pt_oor)
                  || (state_reg == S_PT);
        lbl_diff  = (lbl_rd_reg != bidx_reg[CL_AW-1:0]);
        lbl_we    = pt_we || (state_reg == S_CLR) || ((state_reg == S_ACC) && lbl_diff);
        lbl_wdata = (state_reg == S_ACC) ? bidx_reg[CL_AW-1:0] : '0;

        // center memory port
        ct_addr = (state_reg == S_IDLE) ? req_ct_addr : ci_reg[CL_AW-1:0];
        ct_we   = (accept && (req_type == REQ_LOAD_CENTER) && !ct_oor)
                  || (state_reg == S_WR);
        ct_re   = (accept && (req_type == REQ_READ_CENTER) && !ct_oor)
                  || (state_reg == S_CRD);
        ct_wx   = (state_reg == S_IDLE) ? coord_x : newx_reg;
        ct_wy   = (state_reg == S_IDLE) ? coord_y : newy_reg;

        // accumulators: best index while accumulating, center index in update
        acc_addr = (state_reg == S_ACC) ? bidx_reg[CL_AW-1:0] : ci_reg[CL_AW-1:0];
        acc_x    = sum_x_reg[acc_addr];
        acc_y    = sum_y_reg[acc_addr];
        acc_cnt  = cnt_reg[acc_addr];

        dist_sum = DST_W'(sqx_reg) + DST_W'(sqy_reg);

        // one restoring division step
        rem_sh  = {dr_reg[CNT_W-1:0], dq_reg[SUM_W-1]};
        rem_ge  = (rem_sh >= {1'b0, dcnt_reg});
        dr_next = rem_ge ? (rem_sh - {1'b0, dcnt_reg}) : rem_sh;
        dq_next = {dq_reg[SUM_W-2:0], rem_ge};

        rounds_next = (rounds_reg == ROUND_CAP) ? rounds_reg : rounds_reg + ITER_W'(1);
    end

    // point, label and center memories with registered read data
    always_ff @(posedge clk)
    begin
        if (pt_we)
        begin
            pt_x_mem[pt_addr] <= coord_x;
            pt_y_mem[pt_addr] <= coord_y;
        end
        if (pt_re)
        begin
            px_rd_reg <= pt_x_mem[pt_addr];
            py_rd_reg <= pt_y_mem[pt_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (lbl_we)
            lbl_mem[pt_addr] <= lbl_wdata;
        if (pt_re)
            lbl_rd_reg <= lbl_mem[pt_addr];
    end

    always_ff @(posedge clk)
    begin
        if (ct_we)
        begin
            ct_x_mem[ct_addr] <= ct_wx;
            ct_y_mem[ct_addr] <= ct_wy;
        end
        if (ct_re)
        begin
            cx_rd_reg <= ct_x_mem[ct_addr];
            cy_rd_reg <= ct_y_mem[ct_addr];
        end
    end

    // sequencer, datapath registers and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_CLR;
            point_count_reg   <= PCOUNT_W'(1);
            cluster_count_reg <= KCOUNT_W'(1);
            pi_reg            <= '0;
            ci_reg            <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_POINT_COUNT:   point_count_reg   <= PCOUNT_W'(cfg_data);
                    CFG_CLUSTER_COUNT: cluster_count_reg <= KCOUNT_W'(cfg_data);
                    default: ;
                endcase
            end

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_CLR:
                begin
                    // zero one label per cycle
                    pi_reg <= pi_reg + CNT_W'(1);
                    if (pi_reg == PT_LAST)
                        state_reg <= S_IDLE;
                end

                S_IDLE:
                begin
                    if (accept)
                    begin
                        rq_reg <= req_type;
                        case (req_type)
                            REQ_READ_LABEL, REQ_READ_CENTER:
                            begin
                                if (((req_type == REQ_READ_LABEL) && pt_oor) ||
                                    ((req_type == REQ_READ_CENTER) && ct_oor))
                                begin
                                    label_reg     <= '0;
                                    cx_out_reg    <= '0;
                                    cy_out_reg    <= '0;
                                    iter_reg      <= '0;
                                    status_reg    <= 1'b1;
                                end
                                else
                                    state_reg <= S_RESP;
                            end
                            REQ_RUN:
                            begin
                                pi_reg      <= '0;
                                ci_reg      <= '0;
                                rounds_reg  <= '0;
                                changed_reg <= 1'b0;
                                for (int j = 0; j < MAX_CLUSTERS; j++)
                                begin
                                    sum_x_reg[j] <= '0;
                                    sum_y_reg[j] <= '0;
                                    cnt_reg[j]   <= '0;
                                end
                                state_reg <= (n_eff == '0) ? S_UPD : S_PT;
                            end
                            default:
                            begin
                                // loads and unknown codes answer at once
                                label_reg     <= '0;
                                cx_out_reg    <= '0;
                                cy_out_reg    <= '0;
                                iter_reg      <= '0;
                                status_reg    <= ((req_type == REQ_LOAD_POINT) && pt_oor) ||
                                                 ((req_type == REQ_LOAD_CENTER) && ct_oor);
                            end
                        endcase
                    end
                end

                S_RESP:
                begin
                    if (slot_free)
                    begin
                        iter_reg      <= '0;
                        status_reg    <= 1'b0;
                        if (rq_reg == REQ_READ_LABEL)
                        begin
                            label_reg  <= LABEL_W'(lbl_rd_reg);
                            cx_out_reg <= '0;
                            cy_out_reg <= '0;
                        end
                        else
                        begin
                            label_reg  <= '0;
                            cx_out_reg <= cx_rd_reg;
                            cy_out_reg <= cy_rd_reg;
                        end
                        state_reg <= S_IDLE;
                    end
                end

                // assign step: point read, then each center through the CRD, DIFF, SQ and CMP states
                S_PT:
                begin
                    ci_reg    <= '0;
                    state_reg <= S_CRD;
                end

                S_CRD:
                    state_reg <= S_DIFF;

                S_DIFF:
                begin
                    dx_reg    <= $signed({px_rd_reg[COORD_BITS-1], px_rd_reg})
                                 - $signed({cx_rd_reg[COORD_BITS-1], cx_rd_reg});
                    dy_reg    <= $signed({py_rd_reg[COORD_BITS-1], py_rd_reg})
                                 - $signed({cy_rd_reg[COORD_BITS-1], cy_rd_reg});
                    state_reg <= S_SQ;
                end

                S_SQ:
                begin
                    // full-width signed products, always nonnegative
                    sqx_reg   <= dx_reg * dx_reg;
                    sqy_reg   <= dy_reg * dy_reg;
                    state_reg <= S_CMP;
                end

                S_CMP:
                begin
                    // strict less keeps the lowest index on a tie
                    if ((ci_reg == '0) || (dist_sum < best_reg))
                    begin
                        best_reg <= dist_sum;
                        bidx_reg <= ci_reg;
                    end
                    if (ci_reg == k_eff - CK_W'(1))
                        state_reg <= S_ACC;
                    else
                    begin
                        ci_reg    <= ci_reg + CK_W'(1);
                        state_reg <= S_CRD;
                    end
                end

                S_ACC:
                begin
                    if (lbl_diff)
                        changed_reg <= 1'b1;
                    sum_x_reg[acc_addr] <= acc_x + sext(px_rd_reg);
                    sum_y_reg[acc_addr] <= acc_y + sext(py_rd_reg);
                    cnt_reg[acc_addr]   <= acc_cnt + CNT_W'(1);
                    pi_reg <= pi_reg + CNT_W'(1);
                    if (pi_reg + CNT_W'(1) == n_eff)
                    begin
                        ci_reg    <= '0;
                        state_reg <= S_UPD;
                    end
                    else
                        state_reg <= S_PT;
                end

                // update step: mean of each nonempty cluster
                S_UPD:
                begin
                    if (ci_reg == k_eff)
                        state_reg <= S_ROUND;
                    else if (acc_cnt == '0)
                        ci_reg <= ci_reg + CK_W'(1);
                    else
                    begin
                        dq_reg    <= mag_of(acc_x);
                        dneg_reg  <= acc_x[SUM_W-1];
                        dr_reg    <= '0;
                        dcnt_reg  <= acc_cnt;
                        dstep_reg <= '0;
                        state_reg <= S_DIVX;
                    end
                end

                S_DIVX:
                begin
                    if (dstep_reg == DIV_LAST)
                    begin
                        newx_reg  <= signed_q(dq_next, dneg_reg);
                        dq_reg    <= mag_of(acc_y);
                        dneg_reg  <= acc_y[SUM_W-1];
                        dr_reg    <= '0;
                        dstep_reg <= '0;
                        state_reg <= S_DIVY;
                    end
                    else
                    begin
                        dq_reg    <= dq_next;
                        dr_reg    <= dr_next;
                        dstep_reg <= dstep_reg + DS_W'(1);
                    end
                end

                S_DIVY:
                begin
                    dq_reg    <= dq_next;
                    dr_reg    <= dr_next;
                    dstep_reg <= dstep_reg + DS_W'(1);
                    if (dstep_reg == DIV_LAST)
                    begin
                        newy_reg  <= signed_q(dq_next, dneg_reg);
                        state_reg <= S_WR;
                    end
                end

                S_WR:
                begin
                    ci_reg    <= ci_reg + CK_W'(1);
                    state_reg <= S_UPD;
                end

                S_ROUND:
                begin
                    rounds_reg <= rounds_next;
                    if (changed_reg && (rounds_next != ROUND_CAP))
                    begin
                        pi_reg      <= '0;
                        ci_reg      <= '0;
                        changed_reg <= 1'b0;
                        for (int j = 0; j < MAX_CLUSTERS; j++)
                        begin
                            sum_x_reg[j] <= '0;
                            sum_y_reg[j] <= '0;
                            cnt_reg[j]   <= '0;
                        end
                        state_reg <= (n_eff == '0) ? S_UPD : S_PT;
                    end
                    else
                        state_reg <= S_DONE;
                end

                S_DONE:
                begin
                    if (slot_free)
                    begin
                        label_reg     <= '0;
                        cx_out_reg    <= '0;
                        cy_out_reg    <= '0;
                        iter_reg      <= rounds_reg;
                        status_reg    <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                end

                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid  = out_valid_reg;
    assign label      = label_reg;
    assign center_x   = cx_out_reg;
    assign center_y   = cy_out_reg;
    assign iterations = iter_reg;
    assign status     = status_reg;

    // a run holds the input side closed on the next cycle
    `KMC_ASSERT_NEXT(a_run_busy, clk, rst_n, accept && (req_type == REQ_RUN), !in_ready, "run request did not block input")
    // the winning center is always one in use
    `KMC_ASSERT_NOW(a_best_in_range, clk, rst_n, state_reg == S_ACC, bidx_reg < k_eff, "assigned label out of range")
    // a result is never placed over one still waiting
    `KMC_ASSERT_NEXT(a_no_overwrite, clk, rst_n, out_valid_reg && !out_ready, out_valid_reg && $stable(iter_reg) && $stable(label_reg), "pending result overwritten")

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// tb_top: self-checking testbench for the 2-d k-means block, kmeans_clustering_2d
// depends on kmc_pkg and the block's rtl; holds its own model of stores, labels and runs
`timescale 1ns / 1ps

import kmc_pkg::*;

typedef struct {
    logic [LABEL_W-1:0] label;
    int                 cx;
    int                 cy;
    logic [ITER_W-1:0]  iters;
    logic               status;
} kmc_result_t;

class kmc_scoreboard;
    int          px [MAX_POINTS_DEF];
    int          py [MAX_POINTS_DEF];
    int          lab [MAX_POINTS_DEF];
    int          cx [MAX_CLUSTERS_DEF];
    int          cy [MAX_CLUSTERS_DEF];
    int          pcount;
    int          kcount;
    kmc_result_t pending_q[$];
    int          errors;
    int          runs;
    longint      rounds_total;

    function new();
        pcount = 1;
        kcount = 1;
        errors = 0;
        runs = 0;
        rounds_total = 0;
        foreach (lab[i]) lab[i] = 0;
    endfunction

    // registers keep only their own width
    function void set_reg(logic [CFG_IDX_W-1:0] idx, int val);
        if (idx == CFG_POINT_COUNT)
            pcount = val & ((1 << PCOUNT_W) - 1);
        else
            kcount = val & ((1 << KCOUNT_W) - 1);
    endfunction

    function logic [127:0] sq_dist(int p, int c);
        longint       dx;
        longint       dy;
        logic [127:0] ax;
        logic [127:0] ay;
        dx = longint'(px[p]) - longint'(cx[c]);
        dy = longint'(py[p]) - longint'(cy[c]);
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        return ax * ax + ay * ay;
    endfunction

    // full lloyd iteration until no label moves or the round cap hits
    function int cluster_rounds();
        int           n;
        int           k;
        int           rounds;
        bit           moved;
        longint       sx [MAX_CLUSTERS_DEF];
        longint       sy [MAX_CLUSTERS_DEF];
        int           cnt [MAX_CLUSTERS_DEF];
        int           best;
        logic [127:0] bd;
        logic [127:0] d;
        n = (pcount > MAX_POINTS_DEF) ? MAX_POINTS_DEF : pcount;
        k = (kcount == 0) ? 1 : ((kcount > MAX_CLUSTERS_DEF) ? MAX_CLUSTERS_DEF : kcount);
        rounds = 0;
        do begin
            moved = 0;
            foreach (sx[c])
            begin
                sx[c] = 0;
                sy[c] = 0;
                cnt[c] = 0;
            end
            for (int i = 0; i < n; i++)
            begin
                best = 0;
                bd = sq_dist(i, 0);
                for (int c = 1; c < k; c++)
                begin
                    d = sq_dist(i, c);
                    if (d < bd)
                    begin
                        bd = d;
                        best = c;
                    end
                end
                if (lab[i] != best)
                begin
                    lab[i] = best;
                    moved = 1;
                end
                sx[best] += px[i];
                sy[best] += py[i];
                cnt[best]++;
            end
            // empty clusters keep their old center
            for (int c = 0; c < k; c++)
                if (cnt[c] != 0)
                begin
                    cx[c] = int'(sx[c] / cnt[c]);
                    cy[c] = int'(sy[c] / cnt[c]);
                end
            rounds++;
        end while (moved && rounds < int'(ROUND_CAP));
        return rounds;
    endfunction

    function void note_request(logic [REQ_W-1:0] req, int idx, int x, int y);
        kmc_result_t r;
        r = '{label: '0, cx: 0, cy: 0, iters: '0, status: 1'b0};
        case (req)
            REQ_LOAD_POINT, REQ_READ_LABEL:
                if (idx >= MAX_POINTS_DEF)
                    r.status = 1'b1;
                else if (req == REQ_LOAD_POINT)
                begin
                    px[idx] = x;
                    py[idx] = y;
                    lab[idx] = 0;
                end
                else
                    r.label = LABEL_W'(lab[idx]);
            REQ_LOAD_CENTER, REQ_READ_CENTER:
                if (idx >= MAX_CLUSTERS_DEF)
                    r.status = 1'b1;
                else if (req == REQ_LOAD_CENTER)
                begin
                    cx[idx] = x;
                    cy[idx] = y;
                end
                else
                begin
                    r.cx = cx[idx];
                    r.cy = cy[idx];
                end
            REQ_RUN:
            begin
                r.iters = ITER_W'(cluster_rounds());
                runs++;
                rounds_total += r.iters;
            end
            default: ;
        endcase
        pending_q.push_back(r);
    endfunction

    function void check_result(logic [LABEL_W-1:0] label, int rcx, int rcy,
                               logic [ITER_W-1:0] iters, logic status);
        kmc_result_t e;
        if (pending_q.size() == 0)
        begin
            $error("result with nothing outstanding");
            errors++;
            return;
        end
        e = pending_q.pop_front();
        if (label !== e.label)
        begin
            $error("label: expected %0d actual %0d", e.label, label);
            errors++;
        end
        if (rcx !== e.cx)
        begin
            $error("center_x: expected %h actual %h", e.cx, rcx);
            errors++;
        end
        if (rcy !== e.cy)
        begin
            $error("center_y: expected %h actual %h", e.cy, rcy);
            errors++;
        end
        if (iters !== e.iters)
        begin
            $error("iterations: expected %0d actual %0d", e.iters, iters);
            errors++;
        end
        if (status !== e.status)
        begin
            $error("status: expected %0d actual %0d", e.status, status);
            errors++;
        end
    endfunction

    function int outstanding();
        return pending_q.size();
    endfunction
endclass

module tb_top;
    localparam int        CYCLE_LIMIT      = 5_000_000;
    localparam int        ITEM_TARGET      = 1550;
    localparam int        HOLD_CYCLES      = 600;
    localparam logic [2:0] REQ_UNDEF_FIRST = 3'd5;
    localparam logic [2:0] REQ_UNDEF_LAST  = 3'd7;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic [REQ_W-1:0]       req_type = '0;
    logic [INDEX_W-1:0]     item_index = '0;
    logic signed [31:0]     coord_x = '0;
    logic signed [31:0]     coord_y = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [LABEL_W-1:0]     label;
    logic signed [31:0]     center_x;
    logic signed [31:0]     center_y;
    logic [ITER_W-1:0]      iterations;
    logic                   status;

    kmc_scoreboard sb = new();

    // which store entries hold loaded data, so no read or run touches garbage
    bit  point_loaded [MAX_POINTS_DEF];
    bit  center_loaded [MAX_CLUSTERS_DEF];
    int  items_sent = 0;
    int  burst_left = 0;
    int  cycles = 0;
    bit  hold_done = 1'b0;

    kmeans_clustering_2d dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .req_type   (req_type),
        .item_index (item_index),
        .coord_x    (coord_x),
        .coord_y    (coord_y),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .label      (label),
        .center_x   (center_x),
        .center_y   (center_y),
        .iterations (iterations),
        .status     (status)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("** kmeans_clustering_2d: FAILED **");
            $finish;
        end
    end

    // result monitor: values sampled are the ones from before the edge
    always @(posedge clk)
        if (rst_n && out_valid && out_ready)
            sb.check_result(label, center_x, center_y, iterations, status);

    // receiver: stall pattern in random stretches, plus one long hold-off
    // while the sender keeps pushing, so the block backs up into in_ready
    initial
    begin
        int mode;
        int len;
        forever
        begin
            mode = $urandom_range(0, 3);
            len = $urandom_range(1, 60);
            repeat (len)
            begin
                @(posedge clk);
                if (!hold_done && items_sent > 400)
                begin
                    hold_done = 1'b1;
                    out_ready <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge clk);
                end
                case (mode)
                    0: out_ready <= 1'b1;
                    1: out_ready <= $urandom_range(0, 1);
                    2: out_ready <= ($urandom_range(0, 7) == 0);
                    default: out_ready <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    // one request; valid stays up across back-to-back requests
    task automatic send_request(logic [REQ_W-1:0] req, int idx, int x, int y);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid   <= 1'b1;
        req_type   <= req;
        item_index <= idx[INDEX_W-1:0];
        coord_x    <= x;
        coord_y    <= y;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_request(req, idx, x, y);
        items_sent++;
        if (req == REQ_LOAD_POINT && idx < MAX_POINTS_DEF)
            point_loaded[idx] = 1'b1;
        if (req == REQ_LOAD_CENTER && idx < MAX_CLUSTERS_DEF)
            center_loaded[idx] = 1'b1;
    endtask

    // pause the sender until every outstanding request has its result
    task automatic drain();
        in_valid <= 1'b0;
        burst_left = 0;
        do
            @(posedge clk);
        while (sb.outstanding() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
        sb.set_reg(idx, val);
    endtask

    task automatic set_sizes(int n, int k);
        drain();
        write_reg(CFG_POINT_COUNT, n);
        write_reg(CFG_CLUSTER_COUNT, k);
    endtask

    // coordinate styles: full range, small q16.16, or near a shared base
    function automatic int pick_coord(int style, int base);
        case (style)
            0: return $urandom;
            1: return $signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
            default: return base + $signed($urandom_range(0, 8191)) - 4096;
        endcase
    endfunction

    task automatic load_set(int n, int k);
        int style;
        int bases [4];
        foreach (bases[b]) bases[b] = $urandom;
        style = $urandom_range(0, 2);
        for (int i = 0; i < n; i++)
            if (!point_loaded[i] || $urandom_range(0, 3) != 0)
                send_request(REQ_LOAD_POINT, i, pick_coord(style, bases[i % 4]),
                             pick_coord(style, bases[(i + 1) % 4]));
        for (int c = 0; c < k; c++)
            if (!center_loaded[c] || $urandom_range(0, 2) != 0)
                send_request(REQ_LOAD_CENTER, c, pick_coord(style, bases[c % 4]),
                             pick_coord(style, bases[(c + 1) % 4]));
    endtask

    // stray traffic: unknown codes, bad center indexes, loose label reads
    task automatic noise_request();
        case ($urandom_range(0, 3))
            0: send_request(REQ_W'($urandom_range(REQ_UNDEF_FIRST, REQ_UNDEF_LAST)),
                            $urandom_range(0, 1023), $urandom, $urandom);
            1: send_request(REQ_LOAD_CENTER, $urandom_range(MAX_CLUSTERS_DEF, 1023),
                            $urandom, $urandom);
            2: send_request(REQ_READ_CENTER, $urandom_range(MAX_CLUSTERS_DEF, 1023), 0, 0);
            default: send_request(REQ_READ_LABEL, $urandom_range(0, 1023), 0, 0);
        endcase
    endtask

    task automatic read_back(int n, int k);
        repeat ($urandom_range(1, 6))
            send_request(REQ_READ_LABEL, $urandom_range(0, (n > 0) ? n - 1 : 0), 0, 0);
        for (int c = 0; c < k && c < MAX_CLUSTERS_DEF; c++)
            if (center_loaded[c] && $urandom_range(0, 1) == 0)
                send_request(REQ_READ_CENTER, c, 0, 0);
    endtask

    initial
    begin
        int n;
        int k;
        int phase;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        // let the label clearing pass finish before touching registers
        do
            @(posedge clk);
        while (!in_ready);

        // directed: coordinate extremes, two clusters
        set_sizes(2, 2);
        send_request(REQ_LOAD_POINT, 0, 32'sh7FFF_FFFF, 32'sh8000_0000);
        send_request(REQ_LOAD_POINT, 1, 32'sh8000_0000, 32'sh7FFF_FFFF);
        send_request(REQ_LOAD_CENTER, 0, 0, 0);
        send_request(REQ_LOAD_CENTER, 1, 1, 1);
        send_request(REQ_READ_CENTER, 1, 0, 0);
        send_request(REQ_LOAD_CENTER, MAX_CLUSTERS_DEF, 5, 5);
        send_request(REQ_LOAD_CENTER, 1023, 5, 5);
        send_request(REQ_READ_CENTER, 1023, 0, 0);
        send_request(REQ_READ_LABEL, 1023, 0, 0);
        send_request(REQ_UNDEF_FIRST, 3, 7, 7);
        send_request(REQ_UNDEF_LAST, 1023, -1, -1);
        send_request(REQ_RUN, 0, 0, 0);
        send_request(REQ_READ_LABEL, 0, 0, 0);
        send_request(REQ_READ_LABEL, 1, 0, 0);
        send_request(REQ_READ_CENTER, 0, 0, 0);
        send_request(REQ_READ_CENTER, 1, 0, 0);

        // tie between two centers goes to the lower index; a far center stays empty
        set_sizes(1, 3);
        send_request(REQ_LOAD_POINT, 0, 0, 0);
        send_request(REQ_LOAD_CENTER, 0, 32'sh0001_0000, 0);
        send_request(REQ_LOAD_CENTER, 1, -32'sh0001_0000, 0);
        send_request(REQ_LOAD_CENTER, 2, 32'sh4000_0000, 32'sh4000_0000);
        send_request(REQ_RUN, 0, 0, 0);
        send_request(REQ_READ_LABEL, 0, 0, 0);
        send_request(REQ_READ_CENTER, 2, 0, 0);

        // zero points: one quiet round
        set_sizes(0, 1);
        send_request(REQ_RUN, 0, 0, 0);

        // random phases; one phase loads the whole point store with
        // point_count past the limit and cluster_count zero
        phase = 0;
        while (items_sent < ITEM_TARGET)
        begin
            if (phase == 3)
            begin
                n = 2047;
                k = 0;
                set_sizes(n, k);
                load_set(MAX_POINTS_DEF, 1);
            end
            else
            begin
                case ($urandom_range(0, 9))
                    0: k = MAX_CLUSTERS_DEF;
                    1: k = 31;
                    default: k = $urandom_range(1, 5);
                endcase
                n = (k > 5) ? $urandom_range(1, 8) : $urandom_range(1, 16);
                set_sizes(n, k);
                load_set(n, (k > MAX_CLUSTERS_DEF) ? MAX_CLUSTERS_DEF : k);
            end
            repeat ($urandom_range(0, 3)) noise_request();
            send_request(REQ_RUN, $urandom_range(0, 1023), $urandom, $urandom);
            read_back((n > MAX_POINTS_DEF) ? MAX_POINTS_DEF : n, (k == 0) ? 1 : k);
            // a second run on converged data should take a single round
            if ($urandom_range(0, 3) == 0)
                send_request(REQ_RUN, 0, 0, 0);
            repeat ($urandom_range(0, 2)) noise_request();
            phase++;
        end

        drain();
        repeat (100) @(posedge clk);
        $display("covered %0d requests in %0d phases, %0d runs, %0d rounds in total",
                 items_sent, phase, sb.runs, sb.rounds_total);
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("** kmeans_clustering_2d: PASSED **");
        else
            $display("** kmeans_clustering_2d: FAILED **");
        $finish;
    end
endmodule
